// ----- rtl/core/fbct_pkg.sv -----
`default_nettype none
package fbct_pkg;

	localparam int NUM_PLANES = 6;
	localparam int FRAC_BITS  = 8;
	localparam int PLANE_W    = 64;
	localparam int BOX_W      = 48;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int GRID_W     = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLANE_ZERO  = 3'd0,
		REG_PLANE_ONE   = 3'd1,
		REG_PLANE_TWO   = 3'd2,
		REG_PLANE_THREE = 3'd3,
		REG_PLANE_FOUR  = 3'd4,
		REG_PLANE_FIVE  = 3'd5,
		REG_BOX_ORIGIN  = 3'd6,
		REG_BOX_SIZE    = 3'd7
	} cfg_reg_t;

	// point coordinate width for a given field width: box field plus grid offset plus extent
	function automatic int point_width(input int coord_bits);
		return ((coord_bits > 13) ? coord_bits : 13) + 2;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fbct_corner.sv -----
`default_nettype none
module fbct_corner import fbct_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic [GRID_W-1:0]                       col,
	input  wire logic [GRID_W-1:0]                       row,
	input  wire logic [BOX_W-1:0]                        origin,
	input  wire logic [BOX_W-1:0]                        size,
	input  wire logic [PLANE_W-1:0]                      plane,
	output logic      [2:0][point_width(COORD_BITS)-1:0] pt
);

	localparam int PW  = point_width(COORD_BITS);
	localparam int PPW = (4 * COORD_BITS > PLANE_W) ? 4 * COORD_BITS : PLANE_W;
	localparam int BPW = (3 * COORD_BITS > BOX_W) ? 3 * COORD_BITS : BOX_W;

	logic [PPW-1:0] plane_pad;
	logic [BPW-1:0] origin_pad;
	logic [BPW-1:0] size_pad;
	logic signed [PW-1:0] col_off;
	logic signed [PW-1:0] row_off;
	logic signed [PW-1:0] base [3];

	assign plane_pad  = PPW'(plane);
	assign origin_pad = BPW'(origin);
	assign size_pad   = BPW'(size);

	assign col_off = signed'(PW'({col, FRAC_BITS'(0)}));
	assign row_off = signed'(PW'({row, FRAC_BITS'(0)}));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			base[k] = PW'(signed'(origin_pad[k*COORD_BITS +: COORD_BITS]));
		end
		base[0] = base[0] + col_off;
		base[2] = base[2] - row_off;
		// take the corner nearest the inner side: add the extent where the coefficient is negative
		for (int k = 0; k < 3; k++) begin
			if (plane_pad[k*COORD_BITS + COORD_BITS - 1]) begin
				pt[k] = base[k] + signed'(PW'(size_pad[k*COORD_BITS +: COORD_BITS]));
			end else begin
				pt[k] = base[k];
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fbct_plane.sv -----
`default_nettype none
module fbct_plane import fbct_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  adv,
	input  wire logic [PLANE_W-1:0]                    plane,
	input  wire logic [2:0][point_width(COORD_BITS)-1:0] pt,
	output logic                                       outside
);

	localparam int PW  = point_width(COORD_BITS);
	localparam int MW  = COORD_BITS + PW;
	localparam int SW  = MW + 2;
	localparam int PPW = (4 * COORD_BITS > PLANE_W) ? 4 * COORD_BITS : PLANE_W;

	logic [PPW-1:0] plane_pad;
	logic signed [MW-1:0] prod_s3 [3];
	logic signed [MW-1:0] dterm_s3;
	logic signed [SW-1:0] sum;

	assign plane_pad = PPW'(plane);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				prod_s3[k] <= MW'(signed'(plane_pad[k*COORD_BITS +: COORD_BITS]))
					* MW'(signed'(pt[k]));
			end
			dterm_s3 <= MW'(signed'(plane_pad[3*COORD_BITS +: COORD_BITS])) <<< FRAC_BITS;
		end
	end

	assign sum = SW'(prod_s3[0]) + SW'(prod_s3[1]) + SW'(prod_s3[2]) + SW'(dterm_s3);
	// zero lies on the plane and does not reject
	assign outside = (sum > SW'(0));

endmodule
`default_nettype wire

// ----- rtl/core/frustum_box_cull_test_top.sv -----
// Frustum culling test for one box placed on a grid.
// Input stream s_*: s_tdata carries grid_col in [3:0] and grid_row in [7:4].
// Output stream m_*: m_tdata[0] is inside_res, 1 when the box may be visible,
// 0 when all eight corners lie strictly outside one of the six planes.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge (planes 0..5, then box origin and box size); write only while idle.
// Each plane is tested at its nearest corner, so one multiply per axis and
// plane suffices.
// An accepted item passes the input register, corner selection, products and
// sum/compare into result before its result is valid.
// Throughput: one item per cycle; every stage moves when the next one is
// empty or moving, so the input keeps taking items into empty stages while
// a result waits on m_tready. A stalled receiver fills the four stages, then
// s_tready drops. Reset empties the pipeline and clears the configuration
// registers to 0, which makes every box read as inside.
`default_nettype none
module frustum_box_cull_test_top import fbct_pkg::*; #(
	parameter int GRID_SIZE  = 16,
	parameter int COORD_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // grid_col [3:0], grid_row [7:4]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // inside_res [0], zero [7:1]
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int PW  = point_width(COORD_BITS);
	localparam int GSW = 9;

	logic [PLANE_W-1:0] plane_q [NUM_PLANES];
	logic [BOX_W-1:0]   origin_q;
	logic [BOX_W-1:0]   size_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic [GRID_W-1:0] col_s1, row_s1;
	logic [2:0][PW-1:0] pt_c [NUM_PLANES];
	logic [2:0][PW-1:0] pt_s2 [NUM_PLANES];
	logic [NUM_PLANES-1:0] outside;
	logic inside_s4;

	function automatic logic [GRID_W-1:0] grid_wrap(input logic [GRID_W-1:0] v);
		logic [GSW-1:0] r;
		r = GSW'(v);
		for (int i = 0; i < 8; i++) begin
			if (r >= GSW'(GRID_SIZE)) r = r - GSW'(GRID_SIZE);
		end
		return r[GRID_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) plane_q[p] <= '0;
			origin_q <= '0;
			size_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PLANE_ZERO:  plane_q[0] <= cfg_data;
				REG_PLANE_ONE:   plane_q[1] <= cfg_data;
				REG_PLANE_TWO:   plane_q[2] <= cfg_data;
				REG_PLANE_THREE: plane_q[3] <= cfg_data;
				REG_PLANE_FOUR:  plane_q[4] <= cfg_data;
				REG_PLANE_FIVE:  plane_q[5] <= cfg_data;
				REG_BOX_ORIGIN:  origin_q   <= cfg_data[BOX_W-1:0];
				REG_BOX_SIZE:    size_q     <= cfg_data[BOX_W-1:0];
				default:         ;
			endcase
		end
	end

	assign rdy_s4   = !v_s4 || m_tready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= s_tvalid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			col_s1 <= grid_wrap(s_tdata[3:0]);
			row_s1 <= grid_wrap(s_tdata[7:4]);
		end
		if (rdy_s2) begin
			for (int p = 0; p < NUM_PLANES; p++) pt_s2[p] <= pt_c[p];
		end
		if (rdy_s4) begin
			inside_s4 <= ~|outside;
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		fbct_corner #(.COORD_BITS(COORD_BITS)) u_corner (
			.col    (col_s1),
			.row    (row_s1),
			.origin (origin_q),
			.size   (size_q),
			.plane  (plane_q[p]),
			.pt     (pt_c[p])
		);

		fbct_plane #(.COORD_BITS(COORD_BITS)) u_plane (
			.clk     (clk),
			.adv     (rdy_s3),
			.plane   (plane_q[p]),
			.pt      (pt_s2[p]),
			.outside (outside[p])
		);
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {7'b0, inside_s4};

endmodule
`default_nettype wire

// ----- test/tb_frustum_box_cull_test_top.sv -----
`timescale 1ns / 100ps
module tb_frustum_box_cull_test_top;
	import fbct_pkg::*;

	localparam int FIELD_W        = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 80;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 150;
	localparam int RANDOM_PHASES  = 9;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
	} grid_item_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata   = '0;   // grid_col [3:0], grid_row [7:4]
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [7:0]            m_tdata;          // inside_res [0], zero [7:1]
	logic                  cfg_we    = 1'b0;
	cfg_reg_t              cfg_index = REG_PLANE_ZERO;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// register copies as the block holds them
	logic [PLANE_W-1:0] plane_shadow [NUM_PLANES];
	logic [BOX_W-1:0]   box_min_shadow;
	logic [BOX_W-1:0]   box_ext_shadow;

	// next register setting to load
	logic [CFG_DATA_W-1:0] plane_setup [NUM_PLANES];
	logic [CFG_DATA_W-1:0] origin_setup;
	logic [CFG_DATA_W-1:0] size_setup;

	grid_item_t grid_queue [$];
	logic       inside_expected [$];
	logic       inside_want;
	int         send_idle_pct = 31;
	int         recv_idle_pct = 83;
	bit         rx_hold_req   = 1'b0;
	int         rx_hold_left  = 0;
	int         fail_count    = 0;
	int         idle_cycles   = 0;

	frustum_box_cull_test_top #(
		.GRID_SIZE(16),
		.COORD_BITS(FIELD_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// exact plane test over all eight corners of the placed box
	function automatic logic predict_inside(grid_item_t item);
		longint base [3];
		longint ext [3];
		longint pt [3];
		longint coef [4];
		longint dot;
		bit     all_out;
		for (int k = 0; k < 3; k++) begin
			base[k] = longint'($signed(box_min_shadow[k*FIELD_W +: FIELD_W]));
			ext[k]  = longint'(box_ext_shadow[k*FIELD_W +: FIELD_W]);
		end
		base[0] += longint'(item.col) << FRAC_BITS;
		base[2] -= longint'(item.row) << FRAC_BITS;
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int k = 0; k < 4; k++)
				coef[k] = longint'($signed(plane_shadow[p][k*FIELD_W +: FIELD_W]));
			all_out = 1'b1;
			for (int c = 0; c < 8; c++) begin
				for (int k = 0; k < 3; k++)
					pt[k] = base[k] + (((c >> k) & 1) != 0 ? ext[k] : 64'sd0);
				// d is Q8.8, products are Q.16
				dot = coef[0] * pt[0] + coef[1] * pt[1] + coef[2] * pt[2]
					+ (coef[3] <<< FRAC_BITS);
				if (dot <= 0)
					all_out = 1'b0;
			end
			if (all_out)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// plane facing away from (cx,cy,cz), a few units out along its normal
	function automatic logic [CFG_DATA_W-1:0] frustum_plane(int cx, int cy, int cz);
		int     a, b, c, reach;
		longint qx, qy, qz, dd;
		a     = int'($urandom_range(512)) - 256;
		b     = int'($urandom_range(512)) - 256;
		c     = int'($urandom_range(512)) - 256;
		reach = $urandom_range(6, 1);
		qx    = cx + a * reach;
		qy    = cy + b * reach;
		qz    = cz + c * reach;
		dd    = -((longint'(a) * qx + longint'(b) * qy + longint'(c) * qz) >>> FRAC_BITS);
		return {dd[15:0], c[15:0], b[15:0], a[15:0]};
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_BOX_ORIGIN: box_min_shadow = value[BOX_W-1:0];
			REG_BOX_SIZE:   box_ext_shadow = value[BOX_W-1:0];
			default:        plane_shadow[idx] = value;
		endcase
	endtask

	task automatic apply_setup();
		for (int p = 0; p < NUM_PLANES; p++)
			write_reg(cfg_reg_t'(p), plane_setup[p]);
		write_reg(REG_BOX_ORIGIN, origin_setup);
		write_reg(REG_BOX_SIZE, size_setup);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic fill_setup(logic [CFG_DATA_W-1:0] value);
		for (int p = 0; p < NUM_PLANES; p++)
			plane_setup[p] = value;
		origin_setup = value;
		size_setup   = value;
	endtask

	task automatic random_setup(int kind);
		int cx, cy, cz;
		cx = $urandom_range(16 * 256);
		cy = $urandom_range(512);
		cz = -int'($urandom_range(16 * 256));
		for (int p = 0; p < NUM_PLANES; p++)
			plane_setup[p] = (kind == 2) ? {$urandom, $urandom} : frustum_plane(cx, cy, cz);
		if (kind == 0) begin
			// small box near the cell origin; junk above bit 47 must be dropped
			origin_setup = {16'($urandom), 16'(int'($urandom_range(512)) - 256),
				16'(int'($urandom_range(512)) - 256), 16'(int'($urandom_range(512)) - 256)};
			size_setup   = {16'($urandom), 16'($urandom_range(256)),
				16'($urandom_range(256)), 16'($urandom_range(256))};
		end else begin
			origin_setup = {$urandom, $urandom};
			size_setup   = {$urandom, $urandom};
		end
	endtask

	task automatic queue_item(int col, int row);
		grid_item_t item;
		item.col = col[3:0];
		item.row = row[3:0];
		grid_queue.push_back(item);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (grid_queue.size() != 0 || inside_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// driver: offer queued items, record the expected flag on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				inside_expected.push_back(predict_inside(grid_item_t'(s_tdata)));
				void'(grid_queue.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (grid_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= grid_queue[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready     <= 1'b0;
			rx_hold_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (inside_expected.size() == 0) begin
					$error("inside_res: no item expected, actual %0d", m_tdata[0]);
					fail_count++;
				end else begin
					inside_want = inside_expected.pop_front();
					if (m_tdata[0] !== inside_want) begin
						$error("inside_res mismatch: expected %0d, actual %0d",
							inside_want, m_tdata[0]);
						fail_count++;
					end
				end
			end
			if (rx_hold_req)
				rx_hold_left <= LONG_HOLD;
			else if (rx_hold_left != 0)
				rx_hold_left <= rx_hold_left - 1;
			m_tready <= !rx_hold_req && rx_hold_left == 0 &&
				$urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		for (int p = 0; p < NUM_PLANES; p++)
			plane_shadow[p] = '0;
		box_min_shadow = '0;
		box_ext_shadow = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset planes: everything reads inside
		queue_item(0, 0);
		queue_item(15, 15);
		queue_item(5, 10);
		queue_item(10, 5);
		wait_drained();

		// x > 0 and row > 8 cull; column 0 and row 8 sit exactly on the planes
		fill_setup('0);
		plane_setup[0] = {16'h0000, 16'h0000, 16'h0000, 16'h0100};
		plane_setup[1] = {16'hF800, 16'hFF00, 16'h0000, 16'h0000};
		apply_setup();
		queue_item(0, 0);
		queue_item(1, 0);
		queue_item(0, 8);
		queue_item(0, 9);
		queue_item(15, 15);
		queue_item(0, 15);
		wait_drained();

		// extent with its top bit set must stretch the box up to x = col
		fill_setup('0);
		plane_setup[0] = {16'h0000, 16'h0000, 16'h0000, 16'hFF00};
		origin_setup   = {16'hABCD, 16'h0000, 16'h0000, 16'h8000};
		size_setup     = {16'h1234, 16'hFFFF, 16'hFFFF, 16'h8000};
		apply_setup();
		queue_item(0, 0);
		queue_item(15, 15);
		queue_item(7, 3);
		wait_drained();

		// field extremes
		fill_setup('1);
		apply_setup();
		queue_item(0, 0);
		queue_item(15, 15);
		queue_item(10, 5);
		wait_drained();
		fill_setup(64'h7FFF_7FFF_7FFF_7FFF);
		apply_setup();
		queue_item(0, 15);
		queue_item(15, 0);
		wait_drained();
		fill_setup(64'h8000_8000_8000_8000);
		apply_setup();
		queue_item(3, 12);
		queue_item(12, 3);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 83;
				recv_idle_pct = 31;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_setup(ph % 3);
			apply_setup();
			// hold the receiver off so the pipeline fills and backs up the input
			if (ph == 6)
				rx_hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				queue_item($urandom_range(15), $urandom_range(15));
				// pause the sender until all results are back
				if (ph == 7 && i == PHASE_ITEMS / 2)
					wait_drained();
			end
			if (ph == 6) begin
				@(negedge clk);
				rx_hold_req = 1'b0;
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- frustum_box_cull_test_top.f -----
rtl/core/fbct_pkg.sv
rtl/core/fbct_corner.sv
rtl/core/fbct_plane.sv
rtl/core/frustum_box_cull_test_top.sv
test/tb_frustum_box_cull_test_top.sv
